### rtl/core/aet_pkg.sv
// ----------------------------------------------------------------------------
// aet_pkg: shared types and constants of the active edge table
// Entry layout, store sizing and the sort key compare.
// ----------------------------------------------------------------------------
`default_nettype none

package aet_pkg;

	localparam int MAX_EDGES = 32;
	localparam int Y_BITS    = 12;
	localparam int IDX_W     = $clog2(MAX_EDGES);
	localparam int CNT_W     = $clog2(MAX_EDGES + 1);
	localparam int ADDR_W    = IDX_W + 1;
	localparam int CMP_W     = (Y_BITS > 12) ? Y_BITS : 12;

	typedef logic [Y_BITS-1:0] scan_t;

	typedef struct packed {
		logic signed [29:0] x;
		logic        [11:0] top;
		logic signed [29:0] step;
	} entry_t;

	// true when stored entry a sorts at or after new entry b
	function automatic logic key_ge(entry_t a, entry_t b);
		logic gt_x;
		logic eq_x;
		gt_x = a.x > b.x;
		eq_x = a.x == b.x;
		return gt_x || (eq_x && (a.step >= b.step));
	endfunction

endpackage

`default_nettype wire

### rtl/core/aet_if.sv
// ----------------------------------------------------------------------------
// aet_if: item channels of the active edge table
// Edge command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aet_cmd_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [29:0] edge_x;
	logic        [11:0] edge_top_y;
	logic signed [29:0] edge_step;
	modport source (output valid, action, edge_x, edge_top_y, edge_step, input ready);
	modport sink   (input valid, action, edge_x, edge_top_y, edge_step, output ready);
endinterface

interface aet_res_if;
	logic               valid;
	logic               ready;
	logic        [11:0] scanline;
	logic signed [29:0] out_x;
	logic        [11:0] out_top_y;
	logic signed [29:0] out_step;
	logic               last;
	logic               empty_res;
	logic               overflow;
	modport source (output valid, scanline, out_x, out_top_y, out_step, last, empty_res,
		overflow, input ready);
	modport sink   (input valid, scanline, out_x, out_top_y, out_step, last, empty_res,
		overflow, output ready);
endinterface

`default_nettype wire

### rtl/core/active_edge_table_unit.sv
// ----------------------------------------------------------------------------
// active_edge_table_unit: scanline fill active edge table
// Sorted edge store in a two-bank memory; insertion by shifting entries.
// ----------------------------------------------------------------------------
// add: into an empty store the entry is written at slot 0 directly, else k = entries
//   moved to make room (one per cycle) before it is written; a full store loads one overflow item
//   at the accept edge.
// advance: each source entry is read (S_ADV_RD) and tested (S_ADV_CHK), each
//   kept entry is inserted into the other bank, then each item is read
//   (S_EMIT_RD) and loaded onto the result channel (S_EMIT_LD) when it is free.
// reset clears scanline, edge count and bank select; memory is not cleared.
`default_nettype none

module active_edge_table_unit (
	input  wire         clk,
	input  wire         arst_n,
	aet_cmd_if.sink     edge_in,
	aet_res_if.source   res
);

	typedef enum logic [3:0] {
		S_IDLE, S_INS_RD, S_INS_CMP, S_INS_FIN,
		S_ADV_RD, S_ADV_CHK, S_EMIT_RD, S_EMIT_LD, S_EMIT_EMPTY
	} state_t;

	state_t                   state_q;
	aet_pkg::scan_t           scan_q;
	logic [aet_pkg::CNT_W-1:0] cnt_q, j_q, i_q, m_q, e_q;
	logic                     bank_q, ibank_q, add_q;
	aet_pkg::entry_t          ins_q, rd_q, wd;
	logic                     we, re;
	logic [aet_pkg::ADDR_W-1:0] wa, ra;
	aet_pkg::entry_t          mem [2*aet_pkg::MAX_EDGES];

	logic                     out_free, accept, shift, ins_done, keep, res_load;
	logic [aet_pkg::CNT_W-1:0] j_dec;
	logic [aet_pkg::CMP_W-1:0] scan_w;

	assign out_free = !res.valid || res.ready;
	assign edge_in.ready = (state_q == S_IDLE) && out_free;
	assign accept = edge_in.valid && edge_in.ready;
	assign j_dec = j_q - 1'b1;
	assign shift = aet_pkg::key_ge(rd_q, ins_q);
	assign scan_w = aet_pkg::CMP_W'(scan_q);
	assign keep = aet_pkg::CMP_W'(rd_q.top) >= scan_w;
	assign res_load = (accept && edge_in.action &&
		cnt_q == aet_pkg::CNT_W'(aet_pkg::MAX_EDGES)) ||
		((state_q inside {S_EMIT_LD, S_EMIT_EMPTY}) && out_free);

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = '0;
		ra = '0;
		wd = ins_q;
		ins_done = 1'b0;
		case (state_q)
			S_INS_RD: begin
				if (j_q == '0) begin
					we = 1'b1;
					wa = {ibank_q, aet_pkg::IDX_W'(0)};
					ins_done = 1'b1;
				end else begin
					re = 1'b1;
					ra = {ibank_q, j_dec[aet_pkg::IDX_W-1:0]};
				end
			end
			S_INS_CMP: begin
				we = 1'b1;
				wa = {ibank_q, j_q[aet_pkg::IDX_W-1:0]};
				if (shift) begin
					wd = rd_q;
					if (j_dec != '0) begin
						re = 1'b1;
						ra = {ibank_q, aet_pkg::IDX_W'(j_q - 2'd2)};
					end
				end else begin
					ins_done = 1'b1;
				end
			end
			S_INS_FIN: begin
				we = 1'b1;
				wa = {ibank_q, aet_pkg::IDX_W'(0)};
				ins_done = 1'b1;
			end
			S_ADV_RD: begin
				re = i_q != cnt_q;
				ra = {bank_q, i_q[aet_pkg::IDX_W-1:0]};
			end
			S_EMIT_RD: begin
				re = 1'b1;
				ra = {bank_q, e_q[aet_pkg::IDX_W-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_q    <= '0;
			cnt_q     <= '0;
			bank_q    <= 1'b0;
			res.valid <= 1'b0;
		end else begin
			if (res_load) res.valid <= 1'b1;
			else if (res.ready) res.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (edge_in.action) begin
							if (cnt_q == aet_pkg::CNT_W'(aet_pkg::MAX_EDGES)) begin
								res.scanline  <= scan_w[11:0];
								res.out_x     <= '0;
								res.out_top_y <= '0;
								res.out_step  <= '0;
								res.last      <= 1'b1;
								res.empty_res <= 1'b0;
								res.overflow  <= 1'b1;
							end else begin
								ins_q   <= '{x: edge_in.edge_x, top: edge_in.edge_top_y,
									step: edge_in.edge_step};
								j_q     <= cnt_q;
								ibank_q <= bank_q;
								add_q   <= 1'b1;
								state_q <= S_INS_RD;
							end
						end else begin
							scan_q  <= scan_q + 1'b1;
							i_q     <= '0;
							m_q     <= '0;
							ibank_q <= ~bank_q;
							add_q   <= 1'b0;
							state_q <= S_ADV_RD;
						end
					end
				end
				S_INS_RD: begin
					if (j_q != '0) state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (shift) begin
						j_q <= j_dec;
						if (j_dec == '0) state_q <= S_INS_FIN;
					end
				end
				S_INS_FIN: ;
				S_ADV_RD: begin
					if (i_q == cnt_q) begin
						bank_q  <= ibank_q;
						cnt_q   <= m_q;
						e_q     <= '0;
						state_q <= (m_q == '0) ? S_EMIT_EMPTY : S_EMIT_RD;
					end else begin
						state_q <= S_ADV_CHK;
					end
				end
				S_ADV_CHK: begin
					i_q <= i_q + 1'b1;
					if (keep) begin
						ins_q   <= '{x: rd_q.x + rd_q.step, top: rd_q.top, step: rd_q.step};
						j_q     <= m_q;
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_ADV_RD;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_LD;
				S_EMIT_LD: begin
					if (out_free) begin
						res.scanline  <= scan_w[11:0];
						res.out_x     <= rd_q.x;
						res.out_top_y <= rd_q.top;
						res.out_step  <= rd_q.step;
						res.last      <= (e_q + 1'b1) == cnt_q;
						res.empty_res <= 1'b0;
						res.overflow  <= 1'b0;
						e_q           <= e_q + 1'b1;
						state_q       <= ((e_q + 1'b1) == cnt_q) ? S_IDLE : S_EMIT_RD;
					end
				end
				S_EMIT_EMPTY: begin
					if (out_free) begin
						res.scanline  <= scan_w[11:0];
						res.out_x     <= '0;
						res.out_top_y <= '0;
						res.out_step  <= '0;
						res.last      <= 1'b1;
						res.empty_res <= 1'b1;
						res.overflow  <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// insertion finished: back to idle on add, next source entry on advance
			if (ins_done) begin
				if (add_q) begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_IDLE;
				end else begin
					m_q     <= m_q + 1'b1;
					state_q <= S_ADV_RD;
				end
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= aet_pkg::CNT_W'(aet_pkg::MAX_EDGES))
		else $error("edge count above capacity");

	a_full_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		accept && edge_in.action && cnt_q == aet_pkg::CNT_W'(aet_pkg::MAX_EDGES)
		|=> res.valid && res.overflow && res.last && state_q == S_IDLE)
		else $error("full add did not give overflow item");

	a_no_ovf_adv: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.overflow |-> !(res.empty_res && !res.last))
		else $error("empty item without last mark");

	a_ins_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP) |-> j_q != '0)
		else $error("shift pointer at zero in compare");

	a_add_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_done && add_q |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("add did not grow the store");

endmodule

`default_nettype wire
